// File: rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants of the postfix stack calculator
// Opcodes, status codes, payload structs and controller/datapath links.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int StackDepth = 16;
    localparam int PtrW       = $clog2(StackDepth);
    localparam int CntW       = $clog2(StackDepth + 1);

    localparam logic [3:0] OpPush  = 4'd0;
    localparam logic [3:0] OpNeg   = 4'd1;
    localparam logic [3:0] OpAdd   = 4'd2;
    localparam logic [3:0] OpSub   = 4'd3;
    localparam logic [3:0] OpMul   = 4'd4;
    localparam logic [3:0] OpDiv   = 4'd5;
    localparam logic [3:0] OpFact  = 4'd6;
    localparam logic [3:0] OpMod   = 4'd7;
    localparam logic [3:0] OpPow   = 4'd8;
    localparam logic [3:0] OpClear = 4'd9;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StDivErr = 2'd1;
    localparam logic [1:0] StOvf   = 2'd2;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [1:0]         status;
    } t_out_item;

    // arithmetic unit selection
    typedef enum logic [2:0] {
        AluNeg, AluAdd, AluSub, AluMul, AluDiv, AluMod, AluPow, AluFact
    } t_alu_op;

    // controller to datapath
    typedef struct packed {
        logic    rd_top;     // read top entry into rhs
        logic    rd_next;    // read entry below top into lhs
        logic    start;      // start arithmetic unit
        t_alu_op alu_op;
        logic    wr_push;    // write operand at count
        logic    wr_res;     // write result at index
        logic    [PtrW-1:0] addr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic rhs_zero;
    } t_stat;

endpackage

// File: rtl/rpn_datapath.sv
// ----------------------------------------------------------------------------
// rpn_datapath: stack memory and sequential arithmetic unit
// One memory read port feeds lhs/rhs; shift-add multiply, restoring divide,
// iterated multiply for power (square and multiply) and factorial.
// ----------------------------------------------------------------------------
module rpn_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rpn_pkg::t_cmd        i_cmd,
    input  logic signed [31:0]   i_push_value,
    output rpn_pkg::t_stat       o_stat,
    output logic [31:0]          o_rd_data,
    output logic [31:0]          o_result
);

    logic [31:0] r_mem [rpn_pkg::StackDepth];
    logic [31:0] r_rd;
    logic [31:0] r_lhs, r_rhs, n_lhs, n_rhs;
    logic        r_rd_top, r_rd_next;

    // stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_push) r_mem[i_cmd.addr] <= i_push_value;
        else if (i_cmd.wr_res) r_mem[i_cmd.addr] <= o_result;
        r_rd <= r_mem[i_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_top  <= 1'b0;
            r_rd_next <= 1'b0;
        end else begin
            r_rd_top  <= i_cmd.rd_top;
            r_rd_next <= i_cmd.rd_next;
        end
    end

    // operand capture
    always_comb begin
        n_lhs = r_lhs;
        n_rhs = r_rhs;
        if (r_rd_top)  n_rhs = r_rd;
        if (r_rd_next) n_lhs = r_rd;
    end

    // arithmetic-unit sequencer state
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV, S_POW, S_POW_A, S_POW_S, S_FACT, S_FACT_A, S_FIN
    } t_state;
    t_state      r_state;
    t_state      r_ret;
    logic [31:0] r_acc, r_a, r_b, r_m, r_p, r_e;
    logic [5:0]  r_cnt;
    logic [31:0] r_q, r_rem, r_res;
    logic        r_na, r_nb, r_mod, r_done;
    logic [32:0] w_sub;
    logic [31:0] w_rem_sh;
    logic [31:0] w_prod;
    logic [31:0] w_rem_fin;
    logic [31:0] w_quo_fin;

    assign o_rd_data = r_rd;
    assign o_stat    = '{done: r_done, rhs_zero: (n_rhs == 32'd0)};

    assign w_rem_sh  = {r_rem[30:0], r_q[31]};
    assign w_sub     = {1'b0, w_rem_sh} - {1'b0, r_b};
    assign w_prod    = r_p + (r_b[0] ? r_a : 32'd0);
    assign w_rem_fin = w_sub[32] ? w_rem_sh : w_sub[31:0];
    assign w_quo_fin = {r_q[30:0], ~w_sub[32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_lhs  <= n_lhs;
            r_rhs  <= n_rhs;
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_cnt <= '0;
                        unique case (i_cmd.alu_op)
                            rpn_pkg::AluNeg: begin
                                r_res <= 32'd0 - r_rhs; r_state <= S_FIN;
                            end
                            rpn_pkg::AluAdd: begin
                                r_res <= r_lhs + r_rhs; r_state <= S_FIN;
                            end
                            rpn_pkg::AluSub: begin
                                r_res <= r_lhs - r_rhs; r_state <= S_FIN;
                            end
                            rpn_pkg::AluMul: begin
                                r_a <= r_lhs; r_b <= r_rhs; r_p <= '0;
                                r_ret <= S_FIN; r_state <= S_MUL;
                            end
                            rpn_pkg::AluDiv, rpn_pkg::AluMod: begin
                                r_na  <= r_lhs[31];
                                r_nb  <= r_rhs[31];
                                r_mod <= (i_cmd.alu_op == rpn_pkg::AluMod);
                                r_q   <= r_lhs[31] ? 32'd0 - r_lhs : r_lhs;
                                r_b   <= r_rhs[31] ? 32'd0 - r_rhs : r_rhs;
                                r_rem <= '0;
                                r_state <= S_DIV;
                            end
                            rpn_pkg::AluPow: begin
                                if (r_rhs[31]) begin
                                    if (r_lhs == 32'd1) r_res <= 32'd1;
                                    else if (r_lhs == 32'hFFFF_FFFF)
                                        r_res <= r_rhs[0] ? 32'hFFFF_FFFF : 32'd1;
                                    else r_res <= 32'd0;
                                    r_state <= S_FIN;
                                end else begin
                                    r_acc <= 32'd1; r_m <= r_lhs; r_e <= r_rhs;
                                    r_state <= S_POW;
                                end
                            end
                            default: begin // factorial
                                if (r_rhs[31] || r_rhs < 32'd2) begin
                                    r_res <= 32'd1; r_state <= S_FIN;
                                end else if (r_rhs >= 32'd34) begin
                                    r_res <= 32'd0; r_state <= S_FIN;
                                end else begin
                                    r_acc <= 32'd1; r_m <= r_rhs; r_state <= S_FACT;
                                end
                            end
                        endcase
                    end
                end
                // shift-add multiply r_a*r_b into r_p, 32 steps, then return
                S_MUL: begin
                    r_p   <= w_prod;
                    r_a   <= r_a << 1;
                    r_b   <= r_b >> 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_res   <= w_prod;
                        r_state <= r_ret;
                    end
                end
                // restoring divide, one quotient bit a cycle
                S_DIV: begin
                    if (!w_sub[32]) begin
                        r_rem <= w_sub[31:0];
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        if (r_mod)
                            r_res <= r_na ? 32'd0 - w_rem_fin : w_rem_fin;
                        else
                            r_res <= (r_na != r_nb) ? 32'd0 - w_quo_fin : w_quo_fin;
                        r_state <= S_FIN;
                    end
                end
                // power: multiply on a set exponent bit, else square and shift
                S_POW: begin
                    if (r_e == 32'd0) begin
                        r_res <= r_acc; r_state <= S_FIN;
                    end else if (r_e[0]) begin
                        r_a <= r_acc; r_b <= r_m; r_p <= '0; r_cnt <= '0;
                        r_ret <= S_POW_A; r_state <= S_MUL;
                    end else begin
                        r_a <= r_m; r_b <= r_m; r_p <= '0; r_cnt <= '0;
                        r_e <= r_e >> 1; r_ret <= S_POW_S; r_state <= S_MUL;
                    end
                end
                S_POW_A: begin
                    r_acc   <= r_p;
                    r_e     <= {r_e[31:1], 1'b0};
                    r_state <= S_POW;
                end
                S_POW_S: begin
                    r_m     <= r_p;
                    r_state <= S_POW;
                end
                // factorial: acc *= m, counting m down to 1
                S_FACT: begin
                    if (r_m == 32'd1) begin
                        r_res <= r_acc; r_state <= S_FIN;
                    end else begin
                        r_a <= r_acc; r_b <= r_m; r_p <= '0; r_cnt <= '0;
                        r_m <= r_m - 32'd1; r_ret <= S_FACT_A; r_state <= S_MUL;
                    end
                end
                S_FACT_A: begin
                    r_acc   <= r_p;
                    r_state <= S_FACT;
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result = r_res;

endmodule

// File: rtl/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// rpn_ctrl: controller of the postfix stack calculator
// Holds the stack count, decodes items and sequences memory and ALU.
// ----------------------------------------------------------------------------
module rpn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [3:0]          i_opcode,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic                o_top_zero,
    output logic                o_top_from_res,
    output rpn_pkg::t_cmd       o_cmd,
    input  rpn_pkg::t_stat      i_stat
);

    typedef enum logic [2:0] {
        S_IDLE, S_RD_NEXT, S_WAIT, S_CHECK, S_RUN, S_TOP, S_TOP_WAIT, S_OUT
    } t_state;

    t_state                  r_state;
    logic [rpn_pkg::CntW-1:0] r_cnt;
    logic [3:0]              r_op;
    logic                    r_binary;

    assign o_in_ready = (r_state == S_IDLE) && !o_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.alu_op = rpn_pkg::AluAdd;
        o_cmd.addr = rpn_pkg::PtrW'(r_cnt - rpn_pkg::CntW'(1));
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (i_opcode == rpn_pkg::OpPush) begin
                        o_cmd.addr = rpn_pkg::PtrW'(r_cnt);
                        o_cmd.wr_push = (r_cnt != rpn_pkg::CntW'(rpn_pkg::StackDepth));
                    end else begin
                        o_cmd.rd_top = 1'b1;
                    end
                end
            end
            S_RD_NEXT: begin
                o_cmd.addr = rpn_pkg::PtrW'(r_cnt - rpn_pkg::CntW'(2));
                o_cmd.rd_next = 1'b1;
            end
            S_CHECK: begin
                // no start when a zero divisor clears the stack
                o_cmd.start = !((r_op == rpn_pkg::OpDiv || r_op == rpn_pkg::OpMod)
                                && i_stat.rhs_zero);
                case (r_op)
                    rpn_pkg::OpNeg:  o_cmd.alu_op = rpn_pkg::AluNeg;
                    rpn_pkg::OpSub:  o_cmd.alu_op = rpn_pkg::AluSub;
                    rpn_pkg::OpMul:  o_cmd.alu_op = rpn_pkg::AluMul;
                    rpn_pkg::OpDiv:  o_cmd.alu_op = rpn_pkg::AluDiv;
                    rpn_pkg::OpMod:  o_cmd.alu_op = rpn_pkg::AluMod;
                    rpn_pkg::OpPow:  o_cmd.alu_op = rpn_pkg::AluPow;
                    rpn_pkg::OpFact: o_cmd.alu_op = rpn_pkg::AluFact;
                    default:         o_cmd.alu_op = rpn_pkg::AluAdd;
                endcase
            end
            S_RUN: begin
                if (i_stat.done) begin
                    o_cmd.wr_res = 1'b1;
                    if (r_binary) o_cmd.addr = rpn_pkg::PtrW'(r_cnt - rpn_pkg::CntW'(2));
                end
            end
            S_TOP: o_cmd.rd_top = (r_cnt != '0);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            o_out_valid <= 1'b0;
            o_status <= rpn_pkg::StOk;
            o_top_zero <= 1'b1;
            o_top_from_res <= 1'b0;
            r_op <= '0;
            r_binary <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_op <= i_opcode;
                        r_binary <= (i_opcode != rpn_pkg::OpNeg)
                                 && (i_opcode != rpn_pkg::OpFact);
                        o_status <= rpn_pkg::StOk;
                        case (i_opcode)
                            rpn_pkg::OpPush: begin
                                if (r_cnt == rpn_pkg::CntW'(rpn_pkg::StackDepth)) begin
                                    o_status <= rpn_pkg::StOvf;
                                    r_state <= S_TOP;
                                end else begin
                                    // read back the new top after the write
                                    r_cnt <= r_cnt + rpn_pkg::CntW'(1);
                                    r_state <= S_TOP;
                                end
                            end
                            rpn_pkg::OpNeg, rpn_pkg::OpFact: begin
                                r_state <= (r_cnt != '0) ? S_WAIT : S_TOP;
                            end
                            rpn_pkg::OpAdd, rpn_pkg::OpSub, rpn_pkg::OpMul,
                            rpn_pkg::OpMod, rpn_pkg::OpPow: begin
                                r_state <= (r_cnt >= rpn_pkg::CntW'(2)) ? S_RD_NEXT : S_TOP;
                            end
                            rpn_pkg::OpDiv: begin
                                if (r_cnt >= rpn_pkg::CntW'(2)) r_state <= S_RD_NEXT;
                                else begin
                                    r_cnt <= '0;
                                    o_status <= rpn_pkg::StDivErr;
                                    r_state <= S_TOP;
                                end
                            end
                            rpn_pkg::OpClear: begin
                                r_cnt <= '0;
                                r_state <= S_TOP;
                            end
                            default: r_state <= S_TOP;
                        endcase
                    end
                end
                S_RD_NEXT: r_state <= S_WAIT;
                S_WAIT: r_state <= S_CHECK;
                S_CHECK: begin
                    if ((r_op == rpn_pkg::OpDiv || r_op == rpn_pkg::OpMod)
                        && i_stat.rhs_zero) begin
                        r_cnt <= '0;
                        o_status <= rpn_pkg::StDivErr;
                        r_state <= S_TOP;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (i_stat.done) begin
                        if (r_binary) r_cnt <= r_cnt - rpn_pkg::CntW'(1);
                        o_top_zero <= 1'b0;
                        o_top_from_res <= 1'b1;
                        o_out_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_TOP: r_state <= S_TOP_WAIT;
                S_TOP_WAIT: begin
                    o_top_zero <= (r_cnt == '0);
                    o_top_from_res <= 1'b0;
                    o_out_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator: postfix stack calculator, 32-bit signed integers
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready, i_in_item) takes one item: opcode
// and operand. Output channel (o_out_valid/i_out_ready, o_out_item) returns
// one item per input item: the stack top after the step (0 when empty)
// and a status code.
// One item is worked at a time. Push, clear and operators without enough
// operands only read back the stack top; neg, add and sub are computed directly;
// mul, div and mod use the one-bit-a-cycle shift-add multiplier and
// restoring divider. Power iterates the shared multiplier per exponent bit,
// factorial per factor.
// The stack is a 16-entry memory with one registered read port.
// Reset empties the stack; contents need no clearing. While the receiver
// stalls the result is held and no new item is taken.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rpn_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rpn_pkg::t_out_item   o_out_item
);

    rpn_pkg::t_cmd  w_cmd;
    rpn_pkg::t_stat w_stat;
    logic [31:0]    w_rd, w_res;
    logic           w_top_zero, w_from_res;
    logic [1:0]     w_status;

    rpn_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_in_item.opcode),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (w_status),
        .o_top_zero     (w_top_zero),
        .o_top_from_res (w_from_res),
        .o_cmd          (w_cmd),
        .i_stat         (w_stat)
    );

    rpn_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_push_value (i_in_item.operand_value),
        .o_stat       (w_stat),
        .o_rd_data    (w_rd),
        .o_result     (w_res)
    );

    // result top: zero, ALU result or last read of the top entry
    logic [31:0] r_top;
    always_ff @(posedge i_clk) begin
        if (!o_out_valid) r_top <= w_rd;
    end

    assign o_out_item.top_value = w_top_zero ? 32'sd0 : (w_from_res ? w_res : r_top);
    assign o_out_item.status    = w_status;

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for rpn_stack_evaluator
// Directed table rows cover the empty stack, error clears and wrap cases; a
// full stack then checks overflow. Random push/operator sequences follow.
// Each result is compared against its typed row or a predictor that tracks
// its own copy of the stack. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth      = 16;
    localparam int WatchLimit = 20000;
    localparam int HoldCycles = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    rpn_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_ready;
    rpn_pkg::t_out_item o_out_item;

    rpn_stack_evaluator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // model stack and pending results
    logic [31:0]        calc_stack [Depth];
    int                 calc_count;
    rpn_pkg::t_out_item pending_results [$];

    int errors;
    int items_sent;
    int results_seen;
    int ovf_seen;
    int err_seen;
    int idle_cycles;

    // typed expectation for directed rows, held stable with the item
    logic               row_typed;
    rpn_pkg::t_out_item row_result;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] fact_of(logic [31:0] v);
        logic [31:0] acc;
        acc = 32'd1;
        if (v[31]) return 32'd1;
        if (v >= 32'd34) return 32'd0;
        for (int k = 2; k <= int'(v); k++) acc = acc * 32'(k);
        return acc;
    endfunction

    function automatic logic [31:0] power_of(logic [31:0] base, logic [31:0] ex);
        logic [31:0] acc;
        acc = 32'd1;
        if (ex[31]) begin
            if (base == 32'd1) return 32'd1;
            if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
            return 32'd0;
        end
        while (ex != 32'd0) begin
            if (ex[0]) acc = acc * base;
            base = base * base;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // signed divide via magnitudes: truncating quotient, remainder keeps lhs sign
    function automatic logic [31:0] quot_rem(logic [31:0] a, logic [31:0] b, bit want_rem);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        logic [31:0] r;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q  = ua / ub;
        r  = ua % ub;
        if (want_rem) return a[31] ? -r : r;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // advance the model stack by one item and return the expected result
    function automatic rpn_pkg::t_out_item calc_step(rpn_pkg::t_in_item it);
        rpn_pkg::t_out_item res;
        logic [31:0]        rhs;
        logic [31:0]        lhs;
        logic [31:0]        r;
        res.status = rpn_pkg::StOk;
        case (it.opcode)
            rpn_pkg::OpPush: begin
                if (calc_count < Depth) begin
                    calc_stack[calc_count] = it.operand_value;
                    calc_count++;
                end else begin
                    res.status = rpn_pkg::StOvf;
                end
            end
            rpn_pkg::OpNeg, rpn_pkg::OpFact: begin
                if (calc_count >= 1) begin
                    rhs = calc_stack[calc_count-1];
                    calc_stack[calc_count-1] = (it.opcode == rpn_pkg::OpNeg) ? -rhs
                                                                             : fact_of(rhs);
                end
            end
            rpn_pkg::OpAdd, rpn_pkg::OpSub, rpn_pkg::OpMul, rpn_pkg::OpDiv,
            rpn_pkg::OpMod, rpn_pkg::OpPow: begin
                if (calc_count >= 2 && !((it.opcode == rpn_pkg::OpDiv
                                          || it.opcode == rpn_pkg::OpMod)
                                         && calc_stack[calc_count-1] == 32'd0)) begin
                    rhs = calc_stack[calc_count-1];
                    lhs = calc_stack[calc_count-2];
                    case (it.opcode)
                        rpn_pkg::OpAdd: r = lhs + rhs;
                        rpn_pkg::OpSub: r = lhs - rhs;
                        rpn_pkg::OpMul: r = lhs * rhs;
                        rpn_pkg::OpDiv: r = quot_rem(lhs, rhs, 1'b0);
                        rpn_pkg::OpMod: r = quot_rem(lhs, rhs, 1'b1);
                        default:        r = power_of(lhs, rhs);
                    endcase
                    calc_count--;
                    calc_stack[calc_count-1] = r;
                end else if (it.opcode == rpn_pkg::OpDiv
                             || (it.opcode == rpn_pkg::OpMod && calc_count >= 2)) begin
                    calc_count = 0;
                    res.status = rpn_pkg::StDivErr;
                end
            end
            rpn_pkg::OpClear: calc_count = 0;
            default: ;
        endcase
        res.top_value = (calc_count > 0) ? calc_stack[calc_count-1] : 32'd0;
        return res;
    endfunction

    // predict on input accept, check on output accept
    always @(posedge i_clk) begin
        rpn_pkg::t_out_item predicted;
        rpn_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predicted = calc_step(i_in_item);
                pending_results.push_back(row_typed ? row_result : predicted);
                items_sent++;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (o_out_item.status == rpn_pkg::StOvf) ovf_seen++;
                if (o_out_item.status == rpn_pkg::StDivErr) err_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result top=%0d status=%0d", $realtime,
                             o_out_item.top_value, o_out_item.status);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_item.top_value !== want.top_value) begin
                        $display("%0t: top_value expected %0d actual %0d", $realtime,
                                 want.top_value, o_out_item.top_value);
                        errors++;
                    end
                    if (o_out_item.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 want.status, o_out_item.status);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("%0t: watchdog, no progress, %0d results pending", $realtime,
                     pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(logic [3:0] op, logic [31:0] val, bit typed = 1'b0,
                             logic [31:0] top = '0, logic [1:0] st = rpn_pkg::StOk);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_item.opcode        = op;
        i_in_item.operand_value = val;
        row_typed               = typed;
        row_result.top_value    = top;
        row_result.status       = st;
        i_in_valid              = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'($signed($urandom_range(255)) - 128);
            1: case ($urandom_range(4))
                   0: return 32'd0;
                   1: return 32'd1;
                   2: return 32'hFFFF_FFFF;
                   3: return 32'h7FFF_FFFF;
                   default: return 32'h8000_0000;
               endcase
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_exponent();
        int r;
        r = $urandom_range(19);
        if (r == 0) return $urandom;
        if (r < 3) return 32'($signed($urandom_range(3)) - 4);
        return $urandom_range(40);
    endfunction

    typedef struct {
        logic [3:0]  op;
        logic [31:0] val;
        bit          typed;
        logic [31:0] top;
        logic [1:0]  st;
    } t_row;

    // directed rows; top/st typed where they follow at a glance
    t_row rows [] = '{
        '{rpn_pkg::OpNeg,   32'd9,         1, 32'd0,         rpn_pkg::StOk},    // neg on empty
        '{rpn_pkg::OpAdd,   32'd0,         1, 32'd0,         rpn_pkg::StOk},    // too few
        '{rpn_pkg::OpDiv,   32'd0,         1, 32'd0,         rpn_pkg::StDivErr},// empty div
        '{rpn_pkg::OpPush,  32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, rpn_pkg::StOk},
        '{rpn_pkg::OpMod,   32'd0,         1, 32'h7FFF_FFFF, rpn_pkg::StOk},    // one entry
        '{rpn_pkg::OpPush,  32'd0,         1, 32'd0,         rpn_pkg::StOk},
        '{rpn_pkg::OpMod,   32'd0,         1, 32'd0,         rpn_pkg::StDivErr},// mod by 0
        '{rpn_pkg::OpPush,  32'h8000_0000, 1, 32'h8000_0000, rpn_pkg::StOk},
        '{rpn_pkg::OpPush,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, rpn_pkg::StOk},
        '{rpn_pkg::OpDiv,   32'd0,         1, 32'h8000_0000, rpn_pkg::StOk},    // min / -1
        '{rpn_pkg::OpPush,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, rpn_pkg::StOk},
        '{rpn_pkg::OpMod,   32'd0,         1, 32'd0,         rpn_pkg::StOk},    // min % -1
        '{rpn_pkg::OpPush,  32'd7,         0, 32'd0,         rpn_pkg::StOk},
        '{rpn_pkg::OpPush,  32'hFFFF_FFFE, 0, 32'd0,         rpn_pkg::StOk},
        '{rpn_pkg::OpDiv,   32'd0,         1, 32'hFFFF_FFFD, rpn_pkg::StOk},    // 7 / -2
        '{rpn_pkg::OpPush,  32'd3,         0, 32'd0,         rpn_pkg::StOk},
        '{rpn_pkg::OpPow,   32'd0,         1, 32'hFFFF_FFE5, rpn_pkg::StOk},    // (-3)^3
        '{rpn_pkg::OpPush,  32'hFFFF_FFFF, 0, 32'd0,         rpn_pkg::StOk},
        '{rpn_pkg::OpPow,   32'd0,         1, 32'd0,         rpn_pkg::StOk},    // neg exp
        '{rpn_pkg::OpFact,  32'd0,         1, 32'd1,         rpn_pkg::StOk},    // 0! = 1
        '{rpn_pkg::OpPush,  32'd34,        0, 32'd0,         rpn_pkg::StOk},
        '{rpn_pkg::OpFact,  32'd0,         1, 32'd0,         rpn_pkg::StOk},    // 34! wraps
        '{rpn_pkg::OpSub,   32'd0,         0, 32'd0,         rpn_pkg::StOk},
        '{rpn_pkg::OpClear, 32'd0,         1, 32'd0,         rpn_pkg::StOk},
        '{4'd15,            32'h5A5A_5A5A, 1, 32'd0,         rpn_pkg::StOk}     // unused op
    };

    initial begin
        int          sent;
        int          phase;
        int          r;
        logic [3:0]  op;
        logic [31:0] fill_val;
        errors         = 0;
        items_sent     = 0;
        results_seen   = 0;
        ovf_seen       = 0;
        err_seen       = 0;
        idle_cycles    = 0;
        calc_count     = 0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        row_typed      = 1'b0;
        row_result     = '0;
        fill_val       = '0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_rst_n        = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (rows[k])
            send_item(rows[k].op, rows[k].val, rows[k].typed, rows[k].top, rows[k].st);

        // fill the stack, then one push too many
        for (int k = 0; k < Depth; k++) begin
            fill_val = pick_value();
            send_item(rpn_pkg::OpPush, fill_val);
        end
        send_item(rpn_pkg::OpPush, 32'd1, 1'b1, fill_val, rpn_pkg::StOvf);
        send_item(rpn_pkg::OpPush, 32'd1);
        send_item(rpn_pkg::OpPow, 32'hFFFF_FFFD);
        send_item(rpn_pkg::OpClear, 32'd0);

        // long receiver hold while the sender keeps pushing
        drain();
        hold_req = 1'b1;
        for (int k = 0; k < 6; k++) send_item(rpn_pkg::OpPush, pick_value());
        drain();

        // random sequences in four idle phases
        sent = 0;
        while (sent < 1000) begin
            phase = sent / 250;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            r = $urandom_range(99);
            if (r < 4) begin
                send_item(rpn_pkg::OpClear, pick_value());
                sent++;
            end else if (r < 7) begin
                send_item(4'($urandom_range(15, 10)), pick_value());
                sent++;
            end else if (r < 20) begin
                // operate on what is already stacked
                op = 4'($urandom_range(rpn_pkg::OpDiv, rpn_pkg::OpNeg));
                send_item(op, pick_value());
                sent++;
            end else if (r < 30) begin
                r = $urandom_range(9);
                send_item(rpn_pkg::OpPush,
                          (r < 2) ? $urandom : 32'($signed($urandom_range(45)) - 5));
                send_item(rpn_pkg::OpFact, pick_value());
                sent += 2;
            end else begin
                op = 4'($urandom_range(rpn_pkg::OpPow, rpn_pkg::OpNeg));
                if (op == rpn_pkg::OpFact) op = rpn_pkg::OpMod;
                send_item(rpn_pkg::OpPush, pick_value());
                if (op == rpn_pkg::OpPow)
                    send_item(rpn_pkg::OpPush, pick_exponent());
                else if ((op == rpn_pkg::OpDiv || op == rpn_pkg::OpMod)
                         && $urandom_range(9) == 0)
                    send_item(rpn_pkg::OpPush, 32'd0);
                else
                    send_item(rpn_pkg::OpPush, pick_value());
                send_item(op, pick_value());
                sent += 3;
            end
            // pause until everything has come back
            if (sent % 250 < 3) drain();
        end

        drain();
        repeat (100) @(negedge i_clk);
        $display("Ran %0d items, checked %0d results (%0d overflow, %0d divide errors).",
                 items_sent, results_seen, ovf_seen, err_seen);
        $display("Covered all opcodes, unused codes, stall phases and one long output hold.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending_results.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
